// ===== hw/rtl/lehq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lehq_pkg
// Shared types and codes for the line event hook qualifier.
// ----------------------------------------------------------------------------
package lehq_pkg;

  localparam int CHANNELS_DEFAULT = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [11:0] WINK_LIMIT_RESET  = 12'd150;
  localparam logic [11:0] FLASH_LIMIT_RESET = 12'd750;

  // configuration register indexes
  localparam logic [1:0] REG_WINK_LIMIT  = 2'd0;
  localparam logic [1:0] REG_FLASH_LIMIT = 2'd1;

  // input actions
  localparam logic [3:0] ACT_TICK   = 4'd0;
  localparam logic [3:0] ACT_CHECK  = 4'd1;
  localparam logic [3:0] ACT_LINK   = 4'd2;
  localparam logic [3:0] ACT_HOOK   = 4'd3;
  localparam logic [3:0] ACT_RING   = 4'd4;
  localparam logic [3:0] ACT_TRIP   = 4'd5;
  localparam logic [3:0] ACT_CAS    = 4'd6;
  localparam logic [3:0] ACT_DTMF   = 4'd7;
  localparam logic [3:0] ACT_ALARM  = 4'd8;

  // reported event codes
  localparam logic [3:0] EV_OFFHOOK     = 4'd0;
  localparam logic [3:0] EV_ONHOOK      = 4'd1;
  localparam logic [3:0] EV_FLASH       = 4'd2;
  localparam logic [3:0] EV_WINK        = 4'd3;
  localparam logic [3:0] EV_ALARM_CLEAR = 4'd4;
  localparam logic [3:0] EV_ALARM_TRAP  = 4'd5;
  localparam logic [3:0] EV_RING_START  = 4'd6;
  localparam logic [3:0] EV_RING_STOP   = 4'd7;
  localparam logic [3:0] EV_CAS         = 4'd8;
  localparam logic [3:0] EV_NOOP        = 4'd9;
  localparam logic [3:0] EV_INVALID     = 4'd10;

  // abcd bit masks
  localparam logic [3:0] CAS_A = 4'h8;
  localparam logic [3:0] CAS_B = 4'h4;
  localparam logic [3:0] CAS_C = 4'h2;
  localparam logic [3:0] CAS_D = 4'h1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CHECK,
    OP_HOOK,     // station-side hook, qualified against the marks
    OP_DIRECT    // result fully decoded by the front end
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  chan;
    logic        office;
    logic        level;
    logic [3:0]  code;
    logic [3:0]  cas;
    logic        onhook;
    logic        dvalid;
    logic [7:0]  digit;
  } item_t;

  typedef struct packed {
    logic [4:0]  chan;
    logic [3:0]  code;
    logic [3:0]  cas;
    logic        onhook;
    logic        dvalid;
    logic [7:0]  digit;
    logic        offhook;
  } result_t;

  typedef struct packed {
    logic [11:0] wink_limit;
    logic [11:0] flash_limit;
  } limits_t;

  // abcd -> dcba
  function automatic logic [3:0] reverse_cas(input logic [7:0] v);
    logic [3:0] r;
    r = 4'h0;
    if ((v[3:0] & CAS_A) != 4'h0) r = r | CAS_D;
    if ((v[3:0] & CAS_B) != 4'h0) r = r | CAS_C;
    if ((v[3:0] & CAS_C) != 4'h0) r = r | CAS_B;
    if ((v[3:0] & CAS_D) != 4'h0) r = r | CAS_A;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lehq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lehq_front
// Accepts input items, drops out-of-range channels (ticks are kept), decodes direct events.
// ----------------------------------------------------------------------------
module lehq_front #(
  parameter int CHANNELS = lehq_pkg::CHANNELS_DEFAULT
) (
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [3:0]     action,
  input  wire logic [4:0]     channel,
  input  wire logic           is_station_side,
  input  wire logic           is_office_side,
  input  wire logic           level,
  input  wire logic [7:0]     value,
  input  wire logic           q_full,
  output logic                q_push,
  output lehq_pkg::item_t     q_item
);

  logic in_range;
  logic keep;

  assign in_range = 32'(channel) < 32'(CHANNELS);
  assign in_stall = q_full;

  always_comb begin
    q_item        = '0;
    q_item.chan   = channel;
    q_item.office = is_office_side;
    q_item.level  = level;
    q_item.op     = lehq_pkg::OP_DIRECT;
    q_item.code   = lehq_pkg::EV_NOOP;
    keep          = in_range;
    unique case (action)
      lehq_pkg::ACT_TICK: begin
        q_item.op = lehq_pkg::OP_TICK;
        keep      = 1'b1;
      end
      lehq_pkg::ACT_CHECK: q_item.op = lehq_pkg::OP_CHECK;
      lehq_pkg::ACT_LINK:
        q_item.code = level ? lehq_pkg::EV_ALARM_CLEAR : lehq_pkg::EV_ALARM_TRAP;
      lehq_pkg::ACT_HOOK: begin
        if (is_station_side) begin
          q_item.op = lehq_pkg::OP_HOOK;
        end else begin
          q_item.onhook = 1'b1;
          q_item.code   = level ? lehq_pkg::EV_ONHOOK : lehq_pkg::EV_NOOP;
        end
      end
      lehq_pkg::ACT_RING:
        q_item.code = level ? lehq_pkg::EV_RING_START : lehq_pkg::EV_RING_STOP;
      lehq_pkg::ACT_TRIP:
        q_item.code = level ? lehq_pkg::EV_ONHOOK : lehq_pkg::EV_OFFHOOK;
      lehq_pkg::ACT_CAS: begin
        q_item.code = lehq_pkg::EV_CAS;
        q_item.cas  = lehq_pkg::reverse_cas(value);
      end
      lehq_pkg::ACT_DTMF: begin
        q_item.dvalid = level;
        q_item.digit  = level ? value : 8'h00;
      end
      lehq_pkg::ACT_ALARM: q_item.code = lehq_pkg::EV_NOOP;
      default:             q_item.code = lehq_pkg::EV_INVALID;
    endcase
  end

  assign q_push = in_valid && !q_full && keep;

endmodule
`default_nettype wire

// ===== hw/rtl/lehq_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lehq_queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
module lehq_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lehq_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 pop_valid,
  output lehq_pkg::item_t      pop_item
);

  localparam int QD = lehq_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  lehq_pkg::item_t slots [QD];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = count == CW'(QD);
  assign pop_valid = count != '0;
  assign pop_item  = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QD - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lehq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lehq_back
// Per-channel state, timeout checks and the result register.
// ----------------------------------------------------------------------------
module lehq_back #(
  parameter int CHANNELS = lehq_pkg::CHANNELS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lehq_pkg::limits_t limits,
  input  wire logic              q_valid,
  input  wire lehq_pkg::item_t   q_item,
  output logic                   q_pop,
  output logic                   res_valid,
  output lehq_pkg::result_t      res,
  input  wire logic              res_stall
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t          state;
  lehq_pkg::item_t cur;
  logic [31:0]     now_ms;
  logic [31:0]     stamp_mem [CHANNELS];
  logic [31:0]     stamp_rd;
  logic [CHANNELS-1:0] wink_mark;
  logic [CHANNELS-1:0] flash_mark;
  logic [CHANNELS-1:0] offhook_mark;
  logic [CHANNELS-1:0] stamp_valid;

  logic [IDX_W+4:0] cur_ext;
  logic [IDX_W+4:0] rd_ext;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic             out_free;
  logic             exec_go;
  logic [31:0]      age;
  logic             wink_n, flash_n, off_n, sv_n;
  logic             stamp_wr;
  logic             res_load;
  lehq_pkg::result_t res_n;

  assign cur_ext  = {{IDX_W{1'b0}}, cur.chan};
  assign rd_ext   = {{IDX_W{1'b0}}, q_item.chan};
  assign idx      = cur_ext[IDX_W-1:0];
  assign rd_idx   = rd_ext[IDX_W-1:0];
  assign out_free = !res_valid || !res_stall;
  assign exec_go  = (state == S_EXEC) && out_free;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign age      = now_ms - stamp_rd;

  always_comb begin
    wink_n       = wink_mark[idx];
    flash_n      = flash_mark[idx];
    off_n        = offhook_mark[idx];
    sv_n         = stamp_valid[idx];
    stamp_wr     = 1'b0;
    res_load     = 1'b0;
    res_n        = '0;
    res_n.chan   = cur.chan;
    res_n.code   = cur.code;
    res_n.cas    = cur.cas;
    res_n.onhook = cur.onhook;
    res_n.dvalid = cur.dvalid;
    res_n.digit  = cur.digit;
    unique case (cur.op)
      lehq_pkg::OP_TICK: ;
      lehq_pkg::OP_CHECK: begin
        if (stamp_valid[idx]) begin
          if (wink_mark[idx] && (age > 32'(limits.wink_limit))) begin
            wink_n     = 1'b0;
            flash_n    = 1'b0;
            off_n      = 1'b1;
            sv_n       = 1'b0;
            res_load   = 1'b1;
            res_n.code = lehq_pkg::EV_OFFHOOK;
          end else if (flash_mark[idx] && (age > 32'(limits.flash_limit))) begin
            wink_n       = 1'b0;
            flash_n      = 1'b0;
            off_n        = 1'b0;
            sv_n         = 1'b0;
            res_load     = 1'b1;
            res_n.code   = lehq_pkg::EV_ONHOOK;
            res_n.onhook = cur.office;
          end
        end
      end
      lehq_pkg::OP_HOOK: begin
        stamp_wr = 1'b1;
        sv_n     = 1'b1;
        if (cur.level) begin
          if (!flash_mark[idx]) begin
            wink_n = 1'b1;
          end else begin
            wink_n     = 1'b0;
            flash_n    = 1'b0;
            sv_n       = 1'b0;
            res_load   = 1'b1;
            res_n.code = lehq_pkg::EV_FLASH;
          end
        end else begin
          if (!wink_mark[idx]) begin
            flash_n = 1'b1;
          end else begin
            wink_n     = 1'b0;
            flash_n    = 1'b0;
            sv_n       = 1'b0;
            res_load   = 1'b1;
            res_n.code = lehq_pkg::EV_WINK;
          end
        end
      end
      lehq_pkg::OP_DIRECT: begin
        sv_n     = 1'b0;
        res_load = 1'b1;
      end
    endcase
    res_n.offhook = off_n;
    if (!exec_go) res_load = 1'b0;
  end

  // stamp memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (exec_go && stamp_wr) begin
      stamp_mem[idx] <= now_ms;
    end
    if (q_pop) begin
      stamp_rd <= stamp_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      now_ms       <= '0;
      wink_mark    <= '0;
      flash_mark   <= '0;
      offhook_mark <= '0;
      stamp_valid  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (q_pop) state <= S_EXEC;
        S_EXEC: if (exec_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (exec_go) begin
        if (cur.op == lehq_pkg::OP_TICK) begin
          now_ms <= now_ms + 32'd1;
        end
        wink_mark[idx]    <= wink_n;
        flash_mark[idx]   <= flash_n;
        offhook_mark[idx] <= off_n;
        stamp_valid[idx]  <= sv_n;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res <= res_n;
  end

  a_pop_idle : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("queue popped while an item is in execution");

  a_load_free : assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || !res_stall))
    else $error("result loaded over a waiting result");

  a_tick_silent : assert property (@(posedge clk) disable iff (rst)
    res_load |-> cur.op != lehq_pkg::OP_TICK)
    else $error("tick produced a result");

  a_marks_excl : assert property (@(posedge clk) disable iff (rst)
    (wink_mark & flash_mark) == '0)
    else $error("wink and flash marks both pending on a channel");

  a_exec_follows : assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_EXEC)
    else $error("popped item not taken into execution");

endmodule
`default_nettype wire

// ===== hw/rtl/line_event_hook_qualifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_event_hook_qualifier
// Per-channel hook flash / wink qualifier and line event mapper.
// ----------------------------------------------------------------------------
// Items enter through a front end that drops out-of-range channels and decodes
// the directly mapped events, then pass a two-entry queue to a back end that
// owns the millisecond counter and per-channel marks. The back end handles
// each queued item in two states: in S_IDLE it pops it and reads the channel's
// time stamp from its memory, in S_EXEC it updates state and loads the result
// register, so it takes no new item before it is through with the last one;
// dropped items never enter the queue. A result waits in the output register
// while the queue keeps taking transfers. Channel marks are flip-flops cleared
// at reset, so there is no clearing pass; the stamp memory is only read behind
// a set stamp valid bit. Configuration registers are writable at any cycle
// (cfg_ready is tied high) but should be written only while the block is idle.
// ----------------------------------------------------------------------------
module line_event_hook_qualifier #(
  parameter int CHANNELS = lehq_pkg::CHANNELS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  action,
  input  wire logic [4:0]  channel,
  input  wire logic        is_station_side,
  input  wire logic        is_office_side,
  input  wire logic        level,
  input  wire logic [7:0]  value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       channel_out,
  output logic [3:0]       event_code,
  output logic [3:0]       cas_bits_out,
  output logic             send_onhook,
  output logic             dtmf_valid,
  output logic [7:0]       dtmf_digit,
  output logic             line_offhook
);

  lehq_pkg::limits_t limits;
  lehq_pkg::item_t   push_item;
  lehq_pkg::item_t   pop_item;
  lehq_pkg::result_t res;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;

  // timeout limits; writes to unused indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.wink_limit  <= lehq_pkg::WINK_LIMIT_RESET;
      limits.flash_limit <= lehq_pkg::FLASH_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lehq_pkg::REG_WINK_LIMIT)  limits.wink_limit  <= cfg_data;
      if (cfg_index == lehq_pkg::REG_FLASH_LIMIT) limits.flash_limit <= cfg_data;
    end
  end

  lehq_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .channel         (channel),
    .is_station_side (is_station_side),
    .is_office_side  (is_office_side),
    .level           (level),
    .value           (value),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  lehq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  lehq_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .limits    (limits),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res),
    .res_stall (out_stall)
  );

  // result fields
  assign channel_out  = res.chan;
  assign event_code   = res.code;
  assign cas_bits_out = res.cas;
  assign send_onhook  = res.onhook;
  assign dtmf_valid   = res.dvalid;
  assign dtmf_digit   = res.digit;
  assign line_offhook = res.offhook;

endmodule
`default_nettype wire
